FILE: hw/rtl/integral_image_with_skin_map_assert.svh
// Assertion macros for the checker file of the integral image block.
`ifndef INTEGRAL_IMAGE_WITH_SKIN_MAP_ASSERT_SVH
`define INTEGRAL_IMAGE_WITH_SKIN_MAP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IISM_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IISM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define IISM_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/iism_pkg.sv
// Shared constants, codes and the grey-level function of the integral image block.
package iism_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_COLOR_BITS = 5;

    localparam int SUM_W   = 28;
    localparam int POS_W   = 10;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 2;
    localparam int COMP_W  = 8;
    localparam int GRAY_W  = 8;
    localparam int TIDX_W  = 15;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 80;

    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic OP_PIXEL       = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [CFG_W-1:0] MIN_DIM          = 11'd2;
    localparam logic [CFG_W-1:0] MAX_HEIGHT       = 11'd1024;

    localparam logic [SUM_W-1:0] BORDER_SUM = 28'd1;

    // ITU-R 601 weights scaled by 2^14
    function automatic logic [GRAY_W-1:0] gray_level(
        input logic [COMP_W-1:0] b,
        input logic [COMP_W-1:0] g,
        input logic [COMP_W-1:0] r
    );
        logic [21:0] acc;
        acc = 22'(b) * 22'd1868 + 22'(g) * 22'd9617 + 22'(r) * 22'd4899 + 22'd8192;
        return acc[21:14];
    endfunction

endpackage

FILE: hw/rtl/iism_skin_lut.sv
// Skin score table: one write port, one registered read port.
module iism_skin_lut #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/integral_image_with_skin_map.sv
// Top level: summed-area values of grey level and skin score over a BGR pixel stream.
// Pixels pass the sum stage register, then the output register; table writes give no result.
// Throughput: one request per cycle unless m_ stalls, pixels and table writes alike.
// The line buffer read and the skin table read happen at acceptance, the sums in the next stage.
// Reset (aresetn low, synchronous): position to row 0 column 0, registers to 640 x 480,
// pipeline and output emptied; skin table and line buffer keep their contents.
module integral_image_with_skin_map
    import iism_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // blue, green, red, table_index, table_value, pad
    input  logic              s_tuser,   // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // row_index, column_index, gray_integral,
                                         // skin_integral, pad
    output logic              m_tlast,   // frame_end
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int LINE_AW   = $clog2(MAX_WIDTH);
    localparam int LUT_AW    = 3 * COLOR_BITS;
    localparam int WIDTH_CAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam logic [CFG_W-1:0] WIDTH_CAP_V = CFG_W'(WIDTH_CAP);

    // input fields
    logic [COMP_W-1:0] s_blue, s_green, s_red;
    logic [TIDX_W-1:0] s_table_index;
    logic [COMP_W-1:0] s_table_value;

    assign s_blue        = s_tdata[7:0];
    assign s_green       = s_tdata[15:8];
    assign s_red         = s_tdata[23:16];
    assign s_table_index = s_tdata[38:24];
    assign s_table_value = s_tdata[46:39];

    // configuration
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [CFG_W-1:0] width_eff, height_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg < MIN_DIM) begin
            width_eff = MIN_DIM;
        end else if (frame_width_reg > WIDTH_CAP_V) begin
            width_eff = WIDTH_CAP_V;
        end else begin
            width_eff = frame_width_reg;
        end
        if (frame_height_reg < MIN_DIM) begin
            height_eff = MIN_DIM;
        end else if (frame_height_reg > MAX_HEIGHT) begin
            height_eff = MAX_HEIGHT;
        end else begin
            height_eff = frame_height_reg;
        end
    end

    // handshake
    logic s1_valid_reg, s1_valid_next;
    logic s1_move;
    logic pix_acc, tbl_acc;

    assign s1_move  = s1_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign pix_acc  = s_tvalid && s_tready && (s_tuser == OP_PIXEL);
    assign tbl_acc  = s_tvalid && s_tready && (s_tuser == OP_TABLE_WRITE);

    // position counters
    logic [POS_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [CFG_W-1:0] col_plus, row_plus;
    logic             last_col, last_row;

    assign col_plus = {1'b0, col_reg} + 11'd1;
    assign row_plus = {1'b0, row_reg} + 11'd1;
    assign last_col = (col_plus >= width_eff);
    assign last_row = (row_plus >= height_eff);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[POS_W-1:0];
            end else begin
                col_next = col_plus[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // skin table
    logic [LUT_AW-1:0] lut_rd_addr;
    logic [COMP_W-1:0] skin_score;

    assign lut_rd_addr = {s_blue[COMP_W-1 -: COLOR_BITS], s_green[COMP_W-1 -: COLOR_BITS],
                          s_red[COMP_W-1 -: COLOR_BITS]};

    iism_skin_lut #(
        .ADDR_W (LUT_AW),
        .DATA_W (COMP_W)
    ) u_skin_lut (
        .aclk    (aclk),
        .wr_en   (tbl_acc),
        .wr_addr (LUT_AW'(s_table_index)),
        .wr_data (s_table_value),
        .rd_en   (pix_acc),
        .rd_addr (lut_rd_addr),
        .rd_data (skin_score)
    );

    // sum stage
    logic [POS_W-1:0]  s1_row_reg, s1_col_reg;
    logic              s1_last_reg, s1_border_reg;
    logic [GRAY_W-1:0] s1_gray_reg;

    assign s1_valid_next = pix_acc || (s1_valid_reg && !s1_move);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            s1_last_reg   <= last_col && last_row;
            s1_border_reg <= (row_reg == '0) || (col_reg == '0);
            s1_gray_reg   <= gray_level(s_blue, s_green, s_red);
        end
    end

    // line buffer of the row above: {skin, gray}
    logic [2*SUM_W-1:0] line_mem [MAX_WIDTH];
    logic [2*SUM_W-1:0] line_rd_reg;
    logic [SUM_W-1:0]   gray_up, skin_up, gray_sum, skin_sum;

    assign gray_up = line_rd_reg[SUM_W-1:0];
    assign skin_up = line_rd_reg[2*SUM_W-1:SUM_W];

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            line_mem[LINE_AW'(s1_col_reg)] <= {skin_sum, gray_sum};
        end
        if (pix_acc) begin
            line_rd_reg <= line_mem[LINE_AW'(col_reg)];
        end
    end

    logic [SUM_W-1:0] gray_left_reg, skin_left_reg, gray_upleft_reg, skin_upleft_reg;

    always_comb begin
        if (s1_border_reg) begin
            gray_sum = BORDER_SUM;
            skin_sum = BORDER_SUM;
        end else begin
            gray_sum = SUM_W'(s1_gray_reg) + gray_up + gray_left_reg - gray_upleft_reg;
            skin_sum = SUM_W'(skin_score) + skin_up + skin_left_reg - skin_upleft_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_left_reg   <= BORDER_SUM;
            skin_left_reg   <= BORDER_SUM;
            gray_upleft_reg <= BORDER_SUM;
            skin_upleft_reg <= BORDER_SUM;
        end else if (s1_move) begin
            gray_left_reg   <= gray_sum;
            skin_left_reg   <= skin_sum;
            gray_upleft_reg <= s1_border_reg ? BORDER_SUM : gray_up;
            skin_upleft_reg <= s1_border_reg ? BORDER_SUM : skin_up;
        end
    end

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    assign m_tvalid_next = s1_move || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_tdata_reg <= {4'd0, skin_sum, gray_sum, s1_col_reg, s1_row_reg};
            m_tlast_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hw/rtl/iism_checker.sv
// Port-level checker for the integral image block, with its bind.
`include "integral_image_with_skin_map_assert.svh"

module iism_checker
    import iism_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              m_tlast
);

    `IISM_ASSERT_NEXT_ALWAYS(a_reset_empties_output, aclk, !aresetn, !m_tvalid,
        "output valid after reset")
    `IISM_ASSERT_IMPLY(a_border_is_one, aclk, aresetn,
        m_tvalid && (m_tdata[9:0] == '0 || m_tdata[19:10] == '0),
        m_tdata[47:20] == BORDER_SUM && m_tdata[75:48] == BORDER_SUM,
        "border result not one")
    `IISM_ASSERT_IMPLY(a_frame_end_inside, aclk, aresetn, m_tvalid && m_tlast,
        m_tdata[9:0] != '0 && m_tdata[19:10] != '0, "frame end on row or column zero")
    `IISM_ASSERT_NEXT(a_table_write_no_result, aclk, aresetn,
        s_tvalid && s_tready && s_tuser == OP_TABLE_WRITE && !m_tvalid && s_tready &&
        !$past(s_tvalid && s_tready && s_tuser == OP_PIXEL),
        !m_tvalid, "table write gave a result")
    `IISM_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind integral_image_with_skin_map iism_checker u_iism_checker (.*);
